@@ sv/m3inv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared defaults and width helpers for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

@@ sv/m3inv_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_divider
// Restoring unsigned divider, one quotient bit per register stage. The caller
// guarantees num < den * 2^ELEM_WIDTH, so ELEM_WIDTH quotient bits suffice.
// ----------------------------------------------------------------------------
module m3inv_divider #(
    parameter int ELEM_WIDTH = 32,
    parameter int NUM_WIDTH  = 97,
    parameter int DEN_WIDTH  = 99
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [NUM_WIDTH-1:0]  num_i,
    input  wire logic [DEN_WIDTH-1:0]  den_i,
    output logic      [ELEM_WIDTH-1:0] quo_o
);
    import m3inv_pkg::*;

    localparam int RW = max_int(NUM_WIDTH, DEN_WIDTH + ELEM_WIDTH) + 1;

    logic [NUM_WIDTH-1:0]  rem_reg [ELEM_WIDTH];
    logic [DEN_WIDTH-1:0]  den_reg [ELEM_WIDTH];
    logic [ELEM_WIDTH-1:0] quo_reg [ELEM_WIDTH];
    logic [NUM_WIDTH-1:0]  rem_in  [ELEM_WIDTH];
    logic [DEN_WIDTH-1:0]  den_in  [ELEM_WIDTH];
    logic [ELEM_WIDTH-1:0] quo_in  [ELEM_WIDTH];

    assign rem_in[0] = num_i;
    assign den_in[0] = den_i;
    assign quo_in[0] = '0;

    for (genvar g = 0; g < ELEM_WIDTH; g++) begin : g_step
        localparam int BIT = ELEM_WIDTH - 1 - g;
        logic [RW-1:0] dsh;
        logic [RW-1:0] diff;
        logic          take;

        if (g > 0) begin : g_link
            assign rem_in[g] = rem_reg[g-1];
            assign den_in[g] = den_reg[g-1];
            assign quo_in[g] = quo_reg[g-1];
        end

        assign dsh  = RW'(den_in[g]) << BIT;
        assign take = (RW'(rem_in[g]) >= dsh);
        assign diff = RW'(rem_in[g]) - dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= take ? diff[NUM_WIDTH-1:0] : rem_in[g];
                den_reg[g] <= den_in[g];
                quo_reg[g] <= quo_in[g] | (ELEM_WIDTH'(take) << BIT);
            end
        end
    end

    assign quo_o = quo_reg[ELEM_WIDTH-1];

endmodule
`default_nettype wire

@@ sv/matrix3_inverse_adjugate_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate_top
// Inverse of a signed fixed-point 3x3 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
//  channel   | ports                         | direction
//  ----------+-------------------------------+----------
//  input     | s_valid s_ready s_a00..s_a22  | in
//  result    | m_valid m_ready m_v00..m_v22, | out
//            | m_singular                    |
//
// One matrix enters per cycle while the stages advance; the one-bit-per-stage
// dividers follow seven arithmetic stages and feed the output register.
// All stages advance together whenever the output register is empty or is
// being taken; a stall freezes every stage. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate_top #(
    parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a00,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a01,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a02,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a10,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a11,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a12,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a20,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a21,
    input  wire logic signed [ELEM_WIDTH-1:0] s_a22,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [ELEM_WIDTH-1:0]      m_v00,
    output logic signed [ELEM_WIDTH-1:0]      m_v01,
    output logic signed [ELEM_WIDTH-1:0]      m_v02,
    output logic signed [ELEM_WIDTH-1:0]      m_v10,
    output logic signed [ELEM_WIDTH-1:0]      m_v11,
    output logic signed [ELEM_WIDTH-1:0]      m_v12,
    output logic signed [ELEM_WIDTH-1:0]      m_v20,
    output logic signed [ELEM_WIDTH-1:0]      m_v21,
    output logic signed [ELEM_WIDTH-1:0]      m_v22,
    output logic                              m_singular
);
    import m3inv_pkg::*;

    localparam int W    = ELEM_WIDTH;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int QW   = 2 * W + 1;
    localparam int DETW = 3 * W + 3;
    localparam int NUMW = CW + 2 * FRAC_BITS;
    localparam int RW   = max_int(NUMW, DETW + W) + 1;
    localparam int NST  = W + 8;

    logic          adv;
    logic [NST-1:0] vld_reg;

    logic signed [W-1:0] a_in [9];

    logic signed [PW-1:0]   p_reg  [9];
    logic signed [PW-1:0]   q_reg  [9];
    logic signed [W-1:0]    a0_s1_reg [3];
    logic signed [CW-1:0]   cof_s2_reg [9];
    logic signed [W-1:0]    a0_s2_reg [3];
    logic signed [QW-1:0]   lo_reg [3];
    logic signed [QW-1:0]   hi_reg [3];
    logic signed [CW-1:0]   cof_s3_reg [9];
    logic signed [DETW-1:0] t_reg  [3];
    logic signed [CW-1:0]   cof_s4_reg [9];
    logic signed [DETW-1:0] det_reg;
    logic signed [CW-1:0]   cof_s5_reg [9];
    logic [DETW-1:0]        dmag_s6_reg;
    logic [NUMW-1:0]        num_s6_reg [9];
    logic [8:0]             neg_s6_reg;
    logic                   zero_s6_reg;
    logic [DETW-1:0]        dmag_s7_reg;
    logic [NUMW-1:0]        num_s7_reg [9];
    logic [8:0]             neg_s7_reg;
    logic [8:0]             ovf_s7_reg;
    logic                   zero_s7_reg;
    logic [8:0]             neg_dly_reg [W];
    logic [8:0]             ovf_dly_reg [W];
    logic                   zero_dly_reg [W];
    logic [W-1:0]           quo [9];
    logic signed [W-1:0]    v_reg [9];
    logic                   sing_reg;

    assign adv     = m_ready || !vld_reg[NST-1];
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];

    assign a_in[0] = s_a00;  assign a_in[1] = s_a01;  assign a_in[2] = s_a02;
    assign a_in[3] = s_a10;  assign a_in[4] = s_a11;  assign a_in[5] = s_a12;
    assign a_in[6] = s_a20;  assign a_in[7] = s_a21;  assign a_in[8] = s_a22;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // Stage 1: 2x2 minor products; stage 2: signed cofactors.
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int R0 = (i == 0) ? 1 : 0;
            localparam int R1 = (i == 2) ? 1 : 2;
            localparam int C0 = (j == 0) ? 1 : 0;
            localparam int C1 = (j == 2) ? 1 : 2;
            localparam int K  = i * 3 + j;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    p_reg[K] <= PW'(a_in[R0*3+C0]) * PW'(a_in[R1*3+C1]);
                    q_reg[K] <= PW'(a_in[R0*3+C1]) * PW'(a_in[R1*3+C0]);
                    if (((i + j) % 2) == 1) begin
                        cof_s2_reg[K] <= CW'(q_reg[K]) - CW'(p_reg[K]);
                    end else begin
                        cof_s2_reg[K] <= CW'(p_reg[K]) - CW'(q_reg[K]);
                    end
                end
            end
        end
    end

    // Stages 3..5: determinant along the first row, cofactors split in halves.
    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge aclk) begin
            if (adv) begin
                a0_s1_reg[j] <= a_in[j];
                a0_s2_reg[j] <= a0_s1_reg[j];
                lo_reg[j] <= QW'(a0_s2_reg[j]) * QW'($signed({1'b0, cof_s2_reg[j][W-1:0]}));
                hi_reg[j] <= QW'(a0_s2_reg[j]) * QW'($signed(cof_s2_reg[j][CW-1:W]));
                t_reg[j]  <= (DETW'(hi_reg[j]) <<< W) + DETW'(lo_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cof_s3_reg <= cof_s2_reg;
            cof_s4_reg <= cof_s3_reg;
            cof_s5_reg <= cof_s4_reg;
            det_reg    <= t_reg[0] + t_reg[1] + t_reg[2];
        end
    end

    // Stage 6: magnitudes and quotient signs; stage 7: range check.
    for (genvar i = 0; i < 3; i++) begin : g_orow
        for (genvar j = 0; j < 3; j++) begin : g_ocol
            localparam int K = i * 3 + j;
            localparam int T = j * 3 + i;
            logic [CW-1:0] cmag;
            assign cmag = cof_s5_reg[T][CW-1] ? CW'(-cof_s5_reg[T]) : CW'(cof_s5_reg[T]);
            always_ff @(posedge aclk) begin
                if (adv) begin
                    num_s6_reg[K] <= NUMW'(cmag) << (2 * FRAC_BITS);
                    neg_s6_reg[K] <= cof_s5_reg[T][CW-1] ^ det_reg[DETW-1];
                    num_s7_reg[K] <= num_s6_reg[K];
                    ovf_s7_reg[K] <= (RW'(num_s6_reg[K]) >= (RW'(dmag_s6_reg) << W));
                end
            end

            m3inv_divider #(
                .ELEM_WIDTH (W),
                .NUM_WIDTH  (NUMW),
                .DEN_WIDTH  (DETW)
            ) u_div (
                .aclk  (aclk),
                .en    (adv),
                .num_i (num_s7_reg[K]),
                .den_i (dmag_s7_reg),
                .quo_o (quo[K])
            );

            // Zero on a singular matrix; else saturate to the signed range, then apply the sign.
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (zero_dly_reg[W-1]) begin
                        v_reg[K] <= '0;
                    end else if (neg_dly_reg[W-1][K]) begin
                        if (ovf_dly_reg[W-1][K] || (quo[K][W-1] && |quo[K][W-2:0])) begin
                            v_reg[K] <= $signed({1'b1, {(W-1){1'b0}}});
                        end else begin
                            v_reg[K] <= $signed(-quo[K]);
                        end
                    end else begin
                        if (ovf_dly_reg[W-1][K] || quo[K][W-1]) begin
                            v_reg[K] <= $signed({1'b0, {(W-1){1'b1}}});
                        end else begin
                            v_reg[K] <= $signed(quo[K]);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dmag_s6_reg  <= det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
            zero_s6_reg  <= (det_reg == '0);
            dmag_s7_reg  <= dmag_s6_reg;
            neg_s7_reg   <= neg_s6_reg;
            zero_s7_reg  <= zero_s6_reg;
            neg_dly_reg[0]  <= neg_s7_reg;
            ovf_dly_reg[0]  <= ovf_s7_reg;
            zero_dly_reg[0] <= zero_s7_reg;
            for (int k = 1; k < W; k++) begin
                neg_dly_reg[k]  <= neg_dly_reg[k-1];
                ovf_dly_reg[k]  <= ovf_dly_reg[k-1];
                zero_dly_reg[k] <= zero_dly_reg[k-1];
            end
            sing_reg <= zero_dly_reg[W-1];
        end
    end

    assign m_v00 = v_reg[0];  assign m_v01 = v_reg[1];  assign m_v02 = v_reg[2];
    assign m_v10 = v_reg[3];  assign m_v11 = v_reg[4];  assign m_v12 = v_reg[5];
    assign m_v20 = v_reg[6];  assign m_v21 = v_reg[7];  assign m_v22 = v_reg[8];
    assign m_singular = sing_reg;

endmodule
`default_nettype wire
